### rtl/ilir_pkg.sv
// Shared types and constants for the indexed list insert/remove unit.
// Used by ilir_ctrl, ilir_cell and indexed_list_insert_remove_unit; no dependencies.
package ilir_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);

    // Field widths on the request and result channels
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ         = 3'd0,
        OP_INSERT_AT    = 3'd1,
        OP_INSERT_FIRST = 3'd2,
        OP_INSERT_LAST  = 3'd3,
        OP_REMOVE_AT    = 3'd4,
        OP_REMOVE_FIRST = 3'd5,
        OP_REMOVE_LAST  = 3'd6,
        OP_CLEAR        = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } t_shift;

    // Broadcast to every cell of the row
    typedef struct packed {
        t_shift                mode;
        logic [POS_W-1:0]      at;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_ctrl;

    // Outcome of one request, handed to the output stage
    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               read_ok;
    } t_result;

endpackage

### rtl/indexed_list_insert_remove_unit.sv
// Top level of the indexed list insert/remove unit: a row of entry cells, the
// request decoder and the result register. Depends on ilir_pkg, ilir_ctrl, ilir_cell.
//
// Usage:
//   Requests enter on the slave stream (i_s_tvalid / o_s_tready / i_s_tdata),
//   each carrying an opcode, a position and a value. Every request yields
//   exactly one result on the master stream (o_m_tvalid / i_m_tready /
//   o_m_tdata): the value read, the entry count afterwards and a status.
//   The list lives in a row of CAPACITY cells; an insert or remove moves all
//   cells from the target position on by one place at once, so every
//   request completes at the edge it is accepted.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one request per cycle while i_m_tready is high, set by the
//   shift of the cell row and the single result register.
//   Read: the addressed cell drives a shared OR bus which is registered into
//   the result; reads see the list as it stood before the request.
//   Reset clears the entry count and the result valid flag; the cell
//   contents are left as they are and are never visible below the count.
//   Stall: while a result waits on a low i_m_tready the result register holds
//   and o_s_tready drops, so no further request is taken until it drains.
//   Failed requests (full, out of range, empty) leave the list unchanged.
module indexed_list_insert_remove_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request: [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ilir_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Result: [31:0] read_value, [38:32] entry_count, [40:39] status, [47:41] zero
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ilir_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int POS_LO = ilir_pkg::OPCODE_W;
    localparam int VAL_LO = POS_LO + ilir_pkg::POS_W;
    localparam int CNT_LO = ilir_pkg::VALUE_W;
    localparam int ST_LO  = CNT_LO + ilir_pkg::COUNT_W;
    localparam int PAD_LO = ST_LO + ilir_pkg::STATUS_W;

    logic                            s_accept;
    logic [ilir_pkg::OPCODE_W-1:0]   s_opcode;
    logic [ilir_pkg::POS_W-1:0]      s_position;
    logic [ilir_pkg::VALUE_W-1:0]    s_value;
    ilir_pkg::t_cell_ctrl            s_cell_ctrl;
    ilir_pkg::t_result               s_result;

    logic [ilir_pkg::DATA_WIDTH-1:0] s_data [ilir_pkg::CAPACITY];
    logic [ilir_pkg::DATA_WIDTH-1:0] s_tap  [ilir_pkg::CAPACITY];
    logic [ilir_pkg::DATA_WIDTH-1:0] s_read_bus;

    logic                            r_valid;
    logic [ilir_pkg::VALUE_W-1:0]    r_read_value;
    logic [ilir_pkg::COUNT_W-1:0]    r_count;
    ilir_pkg::t_status               r_status;

    // Unpack the request
    assign s_opcode   = i_s_tdata[ilir_pkg::OPCODE_W-1:0];
    assign s_position = i_s_tdata[VAL_LO-1:POS_LO];
    assign s_value    = i_s_tdata[VAL_LO+ilir_pkg::VALUE_W-1:VAL_LO];

    // Take a request whenever the result register is free or draining
    assign o_s_tready = !r_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    ilir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_opcode    (s_opcode),
        .i_position  (s_position),
        .i_value     (s_value),
        .o_cell_ctrl (s_cell_ctrl),
        .o_result    (s_result)
    );

    // Row of cells; each sees its left and right neighbour, the ends see zero
    for (genvar g = 0; g < ilir_pkg::CAPACITY; g++) begin : g_cell
        logic [ilir_pkg::DATA_WIDTH-1:0] s_left;
        logic [ilir_pkg::DATA_WIDTH-1:0] s_right;

        if (g == 0) begin : g_first
            assign s_left = '0;
        end else begin : g_inner_l
            assign s_left = s_data[g-1];
        end

        if (g == ilir_pkg::CAPACITY - 1) begin : g_last
            assign s_right = '0;
        end else begin : g_inner_r
            assign s_right = s_data[g+1];
        end

        ilir_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (ilir_pkg::IDX_W'(g)),
            .i_ctrl     (s_cell_ctrl),
            .i_left     (s_left),
            .i_right    (s_right),
            .i_read_pos (s_position),
            .o_data     (s_data[g]),
            .o_tap      (s_tap[g])
        );
    end

    // Merge the cell taps; at most one cell drives a non-zero word
    always_comb begin
        s_read_bus = '0;
        for (int k = 0; k < ilir_pkg::CAPACITY; k++) begin
            s_read_bus = s_read_bus | s_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result with the request; hold it while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_read_value <= s_result.read_ok ? ilir_pkg::VALUE_W'(s_read_bus) : '0;
            r_count      <= s_result.count;
            r_status     <= s_result.status;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(ilir_pkg::OUT_TDATA_W-PAD_LO){1'b0}}, r_status, r_count, r_read_value};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_count <= ilir_pkg::CAP_COUNT))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ilir_pkg::ST_FULL) |-> (r_count == ilir_pkg::CAP_COUNT))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ilir_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries present");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_read_value != '0) |-> (r_status == ilir_pkg::ST_OK))
        else $error("read value returned with failing status");
`endif

endmodule

### rtl/ilir_cell.sv
// One storage cell of the list row: holds a single entry and shifts with its neighbours.
// Depends on ilir_pkg.
module ilir_cell (
    input  logic                           i_clk,
    input  logic [ilir_pkg::IDX_W-1:0]     i_index,
    input  ilir_pkg::t_cell_ctrl           i_ctrl,
    input  logic [ilir_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [ilir_pkg::DATA_WIDTH-1:0] i_right,
    input  logic [ilir_pkg::POS_W-1:0]     i_read_pos,
    output logic [ilir_pkg::DATA_WIDTH-1:0] o_data,
    output logic [ilir_pkg::DATA_WIDTH-1:0] o_tap
);

    logic [ilir_pkg::DATA_WIDTH-1:0] r_data;
    logic [ilir_pkg::DATA_WIDTH-1:0] n_data;
    logic [ilir_pkg::POS_W-1:0]      s_index;

    assign s_index = ilir_pkg::POS_W'(i_index);

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.mode)
            ilir_pkg::SH_UP: begin
                priority if (s_index > i_ctrl.at) begin
                    n_data = i_left;
                end else if (s_index == i_ctrl.at) begin
                    n_data = i_ctrl.value;
                end else begin
                    n_data = r_data;
                end
            end
            ilir_pkg::SH_DOWN: begin
                if (s_index >= i_ctrl.at) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Drive the entry onto the read bus only when addressed
    assign o_tap  = (s_index == i_read_pos) ? r_data : '0;

endmodule

### rtl/ilir_ctrl.sv
// Request decoder and entry counter: checks bounds, sets status and steers the cell row.
// Depends on ilir_pkg.
module ilir_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [ilir_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [ilir_pkg::POS_W-1:0]      i_position,
    input  logic [ilir_pkg::VALUE_W-1:0]    i_value,
    output ilir_pkg::t_cell_ctrl            o_cell_ctrl,
    output ilir_pkg::t_result               o_result
);

    logic [ilir_pkg::COUNT_W-1:0] r_count;
    logic [ilir_pkg::COUNT_W-1:0] n_count;
    ilir_pkg::t_shift             s_mode;
    logic [ilir_pkg::POS_W-1:0]   s_at;
    ilir_pkg::t_status            s_status;
    logic                         s_read_ok;
    logic                         s_full;
    logic                         s_empty;

    assign s_full  = (r_count >= ilir_pkg::CAP_COUNT);
    assign s_empty = (r_count == '0);

    always_comb begin
        s_mode    = ilir_pkg::SH_HOLD;
        s_at      = i_position;
        s_status  = ilir_pkg::ST_OK;
        s_read_ok = 1'b0;
        n_count   = r_count;
        unique case (ilir_pkg::t_opcode'(i_opcode))
            ilir_pkg::OP_READ: begin
                priority if (s_empty) begin
                    s_status = ilir_pkg::ST_EMPTY;
                end else if (i_position >= r_count) begin
                    s_status = ilir_pkg::ST_RANGE;
                end else begin
                    s_read_ok = 1'b1;
                end
            end
            ilir_pkg::OP_INSERT_AT, ilir_pkg::OP_INSERT_FIRST, ilir_pkg::OP_INSERT_LAST: begin
                priority if (i_opcode == ilir_pkg::OP_INSERT_FIRST) begin
                    s_at = '0;
                end else if (i_opcode == ilir_pkg::OP_INSERT_LAST) begin
                    s_at = ilir_pkg::POS_W'(r_count);
                end else begin
                    s_at = i_position;
                end
                priority if (s_full) begin
                    s_status = ilir_pkg::ST_FULL;
                end else if (s_at > r_count) begin
                    s_status = ilir_pkg::ST_RANGE;
                end else begin
                    s_mode  = ilir_pkg::SH_UP;
                    n_count = r_count + 1'b1;
                end
            end
            ilir_pkg::OP_REMOVE_AT, ilir_pkg::OP_REMOVE_FIRST, ilir_pkg::OP_REMOVE_LAST: begin
                priority if (i_opcode == ilir_pkg::OP_REMOVE_FIRST) begin
                    s_at = '0;
                end else if (i_opcode == ilir_pkg::OP_REMOVE_LAST) begin
                    s_at = ilir_pkg::POS_W'(r_count - 1'b1);
                end else begin
                    s_at = i_position;
                end
                priority if (s_empty) begin
                    s_status = ilir_pkg::ST_EMPTY;
                end else if (s_at >= r_count) begin
                    s_status = ilir_pkg::ST_RANGE;
                end else begin
                    s_mode  = ilir_pkg::SH_DOWN;
                    n_count = r_count - 1'b1;
                end
            end
            ilir_pkg::OP_CLEAR: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // Hold the row unless a request is taken this cycle
    assign o_cell_ctrl.mode  = i_accept ? s_mode : ilir_pkg::SH_HOLD;
    assign o_cell_ctrl.at    = s_at;
    assign o_cell_ctrl.value = i_value[ilir_pkg::DATA_WIDTH-1:0];

    assign o_result.status  = s_status;
    assign o_result.count   = n_count;
    assign o_result.read_ok = s_read_ok;

endmodule
